// ===== design/dhcp_offer_filter_and_checker_defines.svh =====
// Assertion macros for the DHCP offer filter and checker.
// No dependencies; included by the RTL files that carry assertions.
`ifndef DHCP_OFFER_FILTER_AND_CHECKER_DEFINES_SVH
`define DHCP_OFFER_FILTER_AND_CHECKER_DEFINES_SVH

`ifndef SYNTH
// clocked check, disabled while reset is high
`define DOFC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check that also holds during reset
`define DOFC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DOFC_ASSERT(lbl, clk, rst, prop, msg)
`define DOFC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== design/dofc_pkg.sv =====
// Shared types and constants for the DHCP offer filter and checker.
// No dependencies; imported by every module of the block.
package dofc_pkg;

  localparam int DEF_OPTION_AREA_BYTES = 312;
  localparam int DEF_COUNT_BITS        = 16;

  localparam int FIXED_HEADER_BYTES = 236;
  localparam int MAGIC_BYTES        = 4;
  localparam int MIN_CHECKED_BYTES  = 34;
  localparam int QUEUE_DEPTH        = 2;

  localparam logic [7:0]  OPT_PAD       = 8'h00;
  localparam logic [7:0]  OPT_END       = 8'hFF;
  localparam logic [7:0]  OPT_LEASE     = 8'd51;
  localparam logic [7:0]  OPT_RENEWAL   = 8'd58;
  localparam logic [7:0]  OPT_REBINDING = 8'd59;
  localparam logic [31:0] INFINITE_TIME = 32'hFFFF_FFFF;

  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_WARNING  = 2'd1;
  localparam logic [1:0] STATUS_CRITICAL = 2'd2;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 48;

  localparam logic [CFG_INDEX_BITS-1:0] REG_EXPECTED_XID   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CLIENT_MAC     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WANTED_ADDRESS = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ADDR_CHECK_EN  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SERVER_COUNT   = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SERVER_A       = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SERVER_B       = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SERVER_C       = 3'd7;

  typedef struct packed {
    logic        mode;
    logic [7:0]  data_byte;
    logic [31:0] sender_address;
    logic        last_byte;
  } byte_item_t;

  typedef struct packed {
    logic        kind;
    logic        accepted;
    logic [31:0] offered_ip;
    logic [31:0] lease_seconds;
    logic [31:0] renewal_seconds;
    logic [31:0] rebinding_seconds;
    logic [1:0]  status;
    logic [15:0] offer_total;
    logic [31:0] max_lease_seconds;
    logic        address_seen;
    logic [15:0] server_hits;
  } result_item_t;

  typedef struct packed {
    logic [31:0] expected_xid;
    logic [47:0] client_mac;
    logic [31:0] wanted_address;
    logic        address_check_enable;
    logic [1:0]  server_count;
    logic [31:0] server_a;
    logic [31:0] server_b;
    logic [31:0] server_c;
  } cfg_t;

  // what the parser hands to the accumulator: a packet verdict or a report request
  typedef struct packed {
    logic        kind;
    logic        accepted;
    logic [31:0] yiaddr;
    logic [31:0] lease;
    logic [31:0] renewal;
    logic [31:0] rebinding;
    logic [31:0] sender;
  } event_t;

endpackage

// ===== design/dofc_front.sv =====
// Byte parser: header checks, yiaddr capture and option walk; emits one event per
// packet end or report request. Depends on dofc_pkg and the assertion macro header.
`include "dhcp_offer_filter_and_checker_defines.svh"

module dofc_front #(
  parameter int OPTION_AREA_BYTES = dofc_pkg::DEF_OPTION_AREA_BYTES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_ready,
  input  dofc_pkg::byte_item_t byte_item,
  input  dofc_pkg::cfg_t       cfg,
  input  logic                 queue_full,
  output logic                 event_push,
  output dofc_pkg::event_t     event_item
);
  import dofc_pkg::*;

  localparam int PACKET_BYTES  = FIXED_HEADER_BYTES + OPTION_AREA_BYTES;
  localparam int OPTIONS_START = FIXED_HEADER_BYTES + MAGIC_BYTES;
  localparam int POS_BITS      = $clog2(PACKET_BYTES + 1);

  localparam logic [1:0] PHASE_TYPE   = 2'd0;
  localparam logic [1:0] PHASE_LENGTH = 2'd1;
  localparam logic [1:0] PHASE_DATA   = 2'd2;

  logic [POS_BITS-1:0] byte_position, byte_position_next;
  logic                packet_ok, packet_ok_next;
  logic [1:0]          parse_phase, parse_phase_next;
  logic [7:0]          option_code, option_code_next;
  logic [7:0]          bytes_left, bytes_left_next;
  logic [31:0]         value_shift, value_shift_next;
  logic [31:0]         yiaddr_shift, yiaddr_shift_next;
  logic                options_done, options_done_next;
  logic [2:0]          data_taken, data_taken_next;
  logic [31:0]         held_lease, held_lease_next;
  logic [31:0]         held_renewal, held_renewal_next;
  logic [31:0]         held_rebinding, held_rebinding_next;

  logic       fire, is_byte, in_area, capture;
  logic [7:0] b, xid_byte, mac_byte, bytes_left_dec;
  logic [1:0] xsel;
  logic [2:0] msel;

  assign byte_ready = !queue_full;
  assign fire       = byte_valid && byte_ready;
  assign is_byte    = fire && (byte_item.mode == KIND_VERDICT);
  assign b          = byte_item.data_byte;
  assign in_area    = byte_position < POS_BITS'(PACKET_BYTES);

  // xid bytes 4..7 and mac bytes 28..33 arrive most significant first
  assign xsel     = 2'(2'd3 - byte_position[1:0]);
  assign msel     = 3'(6'd33 - byte_position[5:0]);
  assign xid_byte = cfg.expected_xid[{xsel, 3'b000} +: 8];
  assign mac_byte = cfg.client_mac[{msel, 3'b000} +: 8];
  assign bytes_left_dec = bytes_left - 8'd1;

  always_comb begin
    byte_position_next  = byte_position;
    packet_ok_next      = packet_ok;
    parse_phase_next    = parse_phase;
    option_code_next    = option_code;
    bytes_left_next     = bytes_left;
    value_shift_next    = value_shift;
    yiaddr_shift_next   = yiaddr_shift;
    options_done_next   = options_done;
    data_taken_next     = data_taken;
    held_lease_next     = held_lease;
    held_renewal_next   = held_renewal;
    held_rebinding_next = held_rebinding;
    capture             = 1'b0;

    if (is_byte && in_area) begin
      if (byte_position >= POS_BITS'(4) && byte_position < POS_BITS'(8) && b != xid_byte)
        packet_ok_next = 1'b0;
      if (byte_position >= POS_BITS'(16) && byte_position < POS_BITS'(20))
        yiaddr_shift_next = {yiaddr_shift[23:0], b};
      if (byte_position >= POS_BITS'(28) && byte_position < POS_BITS'(34) && b != mac_byte)
        packet_ok_next = 1'b0;
      if (byte_position >= POS_BITS'(OPTIONS_START) && packet_ok && !options_done) begin
        case (parse_phase)
          PHASE_TYPE: begin
            if (b == OPT_PAD || b == OPT_END) begin
              options_done_next = 1'b1;
            end else begin
              option_code_next = b;
              parse_phase_next = PHASE_LENGTH;
            end
          end
          PHASE_LENGTH: begin
            bytes_left_next  = b;
            value_shift_next = 32'd0;
            data_taken_next  = 3'd0;
            if (b == 8'd0) begin
              capture          = 1'b1;
              parse_phase_next = PHASE_TYPE;
            end else begin
              parse_phase_next = PHASE_DATA;
            end
          end
          default: begin
            // only the first four data bytes shift in
            if (!data_taken[2]) begin
              value_shift_next = {value_shift[23:0], b};
              data_taken_next  = data_taken + 3'd1;
            end
            bytes_left_next = bytes_left_dec;
            if (bytes_left_dec == 8'd0) begin
              capture          = 1'b1;
              parse_phase_next = PHASE_TYPE;
            end
          end
        endcase
      end
      byte_position_next = byte_position + POS_BITS'(1);
    end

    if (capture) begin
      if (option_code == OPT_LEASE)     held_lease_next     = value_shift_next;
      if (option_code == OPT_RENEWAL)   held_renewal_next   = value_shift_next;
      if (option_code == OPT_REBINDING) held_rebinding_next = value_shift_next;
    end

    event_push            = fire && (byte_item.mode == KIND_REPORT || byte_item.last_byte);
    event_item.kind       = byte_item.mode;
    event_item.accepted   = packet_ok_next &&
                            (byte_position_next >= POS_BITS'(MIN_CHECKED_BYTES));
    event_item.yiaddr     = yiaddr_shift_next;
    event_item.lease      = held_lease_next;
    event_item.renewal    = held_renewal_next;
    event_item.rebinding  = held_rebinding_next;
    event_item.sender     = byte_item.sender_address;

    // packet end: per-packet state back to start, held times kept
    if (is_byte && byte_item.last_byte) begin
      byte_position_next = '0;
      packet_ok_next     = 1'b1;
      parse_phase_next   = PHASE_TYPE;
      option_code_next   = 8'd0;
      bytes_left_next    = 8'd0;
      value_shift_next   = 32'd0;
      yiaddr_shift_next  = 32'd0;
      options_done_next  = 1'b0;
      data_taken_next    = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      packet_ok      <= 1'b1;
      parse_phase    <= PHASE_TYPE;
      option_code    <= 8'd0;
      bytes_left     <= 8'd0;
      value_shift    <= 32'd0;
      yiaddr_shift   <= 32'd0;
      options_done   <= 1'b0;
      data_taken     <= 3'd0;
      held_lease     <= 32'd0;
      held_renewal   <= 32'd0;
      held_rebinding <= 32'd0;
    end else begin
      byte_position  <= byte_position_next;
      packet_ok      <= packet_ok_next;
      parse_phase    <= parse_phase_next;
      option_code    <= option_code_next;
      bytes_left     <= bytes_left_next;
      value_shift    <= value_shift_next;
      yiaddr_shift   <= yiaddr_shift_next;
      options_done   <= options_done_next;
      data_taken     <= data_taken_next;
      held_lease     <= held_lease_next;
      held_renewal   <= held_renewal_next;
      held_rebinding <= held_rebinding_next;
    end
  end

  `DOFC_ASSERT(a_pos_reset_on_last, clk, rst, is_byte && byte_item.last_byte |=> byte_position == '0, "byte position not cleared after packet end")
  `DOFC_ASSERT(a_pos_bounded, clk, rst, byte_position <= POS_BITS'(PACKET_BYTES), "byte position past packet size")
  `DOFC_ASSERT(a_done_in_options, clk, rst, options_done |-> byte_position > POS_BITS'(OPTIONS_START), "option walk ended before option area")

endmodule

// ===== design/dofc_queue.sv =====
// Short event queue between the parser and the accumulator.
// Depends on dofc_pkg and the assertion macro header.
`include "dhcp_offer_filter_and_checker_defines.svh"

module dofc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  dofc_pkg::event_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output dofc_pkg::event_t head_item
);
  import dofc_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  event_t              entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full       = count == CNT_BITS'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_BITS'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_BITS'(1);
      if (push && !pop)      count <= count + CNT_BITS'(1);
      else if (pop && !push) count <= count - CNT_BITS'(1);
    end
  end

  `DOFC_ASSERT(a_no_overflow, clk, rst, push |-> !full, "push into full queue")
  `DOFC_ASSERT(a_no_underflow, clk, rst, pop |-> head_valid, "pop from empty queue")
  `DOFC_ASSERT(a_count_step, clk, rst, push && !pop |=> count == $past(count) + CNT_BITS'(1), "queue count did not advance on push")

endmodule

// ===== design/dofc_back.sv =====
// Accumulator: folds packet verdicts into running totals, forms report status and
// holds the result register. Depends on dofc_pkg and the assertion macro header.
`include "dhcp_offer_filter_and_checker_defines.svh"

module dofc_back #(
  parameter int COUNT_BITS = dofc_pkg::DEF_COUNT_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dofc_pkg::cfg_t         cfg,
  input  logic                   head_valid,
  input  dofc_pkg::event_t       head_item,
  output logic                   pop,
  output logic                   result_valid,
  input  logic                   result_ready,
  output dofc_pkg::result_item_t result_item
);
  import dofc_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] accepted_count, accepted_count_next;
  logic [COUNT_BITS-1:0] server_match_count, server_match_count_next;
  logic [31:0]           lease_maximum, lease_maximum_next;
  logic                  wanted_seen, wanted_seen_next;

  logic [1:0]            hits, status;
  logic [COUNT_BITS:0]   offer_sum;
  logic [COUNT_BITS+1:0] hit_sum;
  logic [31:0]           offer_wide, hits_wide;
  logic                  fold;
  result_item_t          result_next;

  assign pop  = head_valid && (!result_valid || result_ready);
  assign fold = head_item.kind == KIND_VERDICT && head_item.accepted;

  always_comb begin
    hits = 2'(cfg.server_count > 2'd0 && head_item.sender == cfg.server_a)
         + 2'(cfg.server_count > 2'd1 && head_item.sender == cfg.server_b)
         + 2'(cfg.server_count > 2'd2 && head_item.sender == cfg.server_c);
    offer_sum = {1'b0, accepted_count} + (COUNT_BITS+1)'(1);
    hit_sum   = {2'b00, server_match_count} + (COUNT_BITS+2)'(hits);

    accepted_count_next     = accepted_count;
    server_match_count_next = server_match_count;
    lease_maximum_next      = lease_maximum;
    wanted_seen_next        = wanted_seen;
    if (fold) begin
      accepted_count_next = (offer_sum > (COUNT_BITS+1)'(COUNT_MAX)) ? COUNT_MAX
                                                                     : offer_sum[COUNT_BITS-1:0];
      server_match_count_next = (hit_sum > (COUNT_BITS+2)'(COUNT_MAX)) ? COUNT_MAX
                                                                       : hit_sum[COUNT_BITS-1:0];
      if (head_item.lease > lease_maximum || head_item.lease == INFINITE_TIME)
        lease_maximum_next = head_item.lease;
      if (head_item.yiaddr == cfg.wanted_address)
        wanted_seen_next = 1'b1;
    end

    // report status works on totals as they stand
    if (accepted_count == '0)
      status = STATUS_CRITICAL;
    else if (cfg.server_count != 2'd0 && server_match_count == '0)
      status = STATUS_CRITICAL;
    else if (server_match_count < COUNT_BITS'(cfg.server_count))
      status = STATUS_WARNING;
    else if (cfg.address_check_enable && !wanted_seen)
      status = STATUS_WARNING;
    else
      status = STATUS_OK;

    offer_wide = 32'(accepted_count_next);
    hits_wide  = 32'(server_match_count_next);

    result_next.kind              = head_item.kind;
    result_next.lease_seconds     = head_item.lease;
    result_next.renewal_seconds   = head_item.renewal;
    result_next.rebinding_seconds = head_item.rebinding;
    result_next.offer_total       = offer_wide[15:0];
    result_next.max_lease_seconds = lease_maximum_next;
    result_next.address_seen      = wanted_seen_next;
    result_next.server_hits       = hits_wide[15:0];
    if (head_item.kind == KIND_REPORT) begin
      result_next.accepted   = 1'b0;
      result_next.offered_ip = 32'd0;
      result_next.status     = status;
    end else begin
      result_next.accepted   = head_item.accepted;
      result_next.offered_ip = head_item.yiaddr;
      result_next.status     = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) result_item <= result_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid       <= 1'b0;
      accepted_count     <= '0;
      server_match_count <= '0;
      lease_maximum      <= 32'd0;
      wanted_seen        <= 1'b0;
    end else begin
      if (pop) begin
        result_valid       <= 1'b1;
        accepted_count     <= accepted_count_next;
        server_match_count <= server_match_count_next;
        lease_maximum      <= lease_maximum_next;
        wanted_seen        <= wanted_seen_next;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  `DOFC_ASSERT(a_count_monotonic, clk, rst, 1'b1 |=> accepted_count >= $past(accepted_count), "offer count went down")
  `DOFC_ASSERT(a_hits_need_offer, clk, rst, server_match_count != '0 |-> accepted_count != '0, "server hits without an accepted offer")
  `DOFC_ASSERT(a_report_fields, clk, rst, result_valid && result_item.kind == KIND_REPORT |-> !result_item.accepted && result_item.offered_ip == 32'd0, "report carries packet fields")

endmodule

// ===== design/dhcp_offer_filter_and_checker.sv =====
// Top level of the DHCP offer filter and checker: configuration registers,
// parser, event queue and accumulator. Depends on dofc_pkg and the three submodules.
//
//   channel   | handshake                   | payload
//   ----------+-----------------------------+-----------------------
//   bytes in  | byte_valid / byte_ready     | byte_item   (byte_item_t)
//   results   | result_valid / result_ready | result_item (result_item_t)
//   config    | cfg_write                   | cfg_index, cfg_data
//
// One byte or report request is taken per cycle while byte_ready is high;
// a result goes via the event queue to the result register once the output is free.
// A two-entry queue parts the parser from the accumulator, so bytes keep flowing
// while one result waits; byte_ready drops only when that queue is full.
// Synchronous reset clears all but queue entries and result data; no clearing pass.
module dhcp_offer_filter_and_checker #(
  parameter int OPTION_AREA_BYTES = dofc_pkg::DEF_OPTION_AREA_BYTES,
  parameter int COUNT_BITS        = dofc_pkg::DEF_COUNT_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  byte_valid,
  output logic                                  byte_ready,
  input  dofc_pkg::byte_item_t                  byte_item,
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output dofc_pkg::result_item_t                result_item,
  input  logic                                  cfg_write,
  input  logic [dofc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [dofc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import dofc_pkg::*;

  cfg_t   cfg;
  event_t push_item, head_item;
  logic   push, full, pop, head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_EXPECTED_XID:   cfg.expected_xid         <= cfg_data[31:0];
        REG_CLIENT_MAC:     cfg.client_mac           <= cfg_data[47:0];
        REG_WANTED_ADDRESS: cfg.wanted_address       <= cfg_data[31:0];
        REG_ADDR_CHECK_EN:  cfg.address_check_enable <= cfg_data[0];
        REG_SERVER_COUNT:   cfg.server_count         <= cfg_data[1:0];
        REG_SERVER_A:       cfg.server_a             <= cfg_data[31:0];
        REG_SERVER_B:       cfg.server_b             <= cfg_data[31:0];
        REG_SERVER_C:       cfg.server_c             <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  dofc_front #(
    .OPTION_AREA_BYTES(OPTION_AREA_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .cfg        (cfg),
    .queue_full (full),
    .event_push (push),
    .event_item (push_item)
  );

  dofc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  dofc_back #(
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head_valid   (head_valid),
    .head_item    (head_item),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

endmodule

// ===== dv/dhcp_offer_filter_and_checker_test.sv =====
// Testbench for dhcp_offer_filter_and_checker: drives DHCP reply bytes and report
// requests, predicts every verdict and report, and checks each result field by field.
// Depends on dofc_pkg and the RTL of the block.
module dhcp_offer_filter_and_checker_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dofc_pkg::*;

  localparam int OPTIONS_FROM = FIXED_HEADER_BYTES + MAGIC_BYTES;
  localparam int PACKET_LIMIT = FIXED_HEADER_BYTES + DEF_OPTION_AREA_BYTES;
  localparam int unsigned COUNT_LIMIT = (1 << DEF_COUNT_BITS) - 1;
  localparam int SETTLE_CYCLES = 6;
  localparam logic [31:0] MAGIC_COOKIE = 32'h6382_5363;

  typedef enum logic [1:0] {WANT_CODE, WANT_LENGTH, WANT_DATA} option_phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic byte_valid = 1'b0;
  logic byte_ready;
  byte_item_t byte_item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_item_t result_item;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // predicted block state
  cfg_t setting = '0;
  int pkt_pos = 0;
  bit pkt_good = 1'b1;
  option_phase_t walk_phase = WANT_CODE;
  logic [7:0] walk_code = '0;
  logic [7:0] walk_left = '0;
  logic [31:0] walk_value = '0;
  int unsigned walk_taken = 0;
  bit walk_done = 1'b0;
  logic [31:0] yiaddr_acc = '0;
  logic [31:0] lease_kept = '0;
  logic [31:0] renewal_kept = '0;
  logic [31:0] rebinding_kept = '0;
  int unsigned offers = 0;
  logic [31:0] lease_peak = '0;
  bit wanted_hit = 1'b0;
  int unsigned server_hit_sum = 0;

  result_item_t outcomes_due[$];
  logic [7:0] packet_bytes[$];
  int unsigned mismatches = 0;
  bit quiet_sender = 1'b0;
  bit quiet_receiver = 1'b0;

  dhcp_offer_filter_and_checker uut (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .byte_item(byte_item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_item(result_item),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic int unsigned draw_pause(input bit quiet);
    if (quiet) return 0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 0;
      5, 6, 7: return $urandom_range(1, 3);
      default: return $urandom_range(0, 17);
    endcase
  endfunction

  function automatic cfg_t make_settings(input logic [31:0] xid, input logic [47:0] mac,
                                         input logic [31:0] wanted, input logic check,
                                         input logic [1:0] count, input logic [31:0] a,
                                         input logic [31:0] b, input logic [31:0] c);
    cfg_t s;
    s.expected_xid = xid;
    s.client_mac = mac;
    s.wanted_address = wanted;
    s.address_check_enable = check;
    s.server_count = count;
    s.server_a = a;
    s.server_b = b;
    s.server_c = c;
    return s;
  endfunction

  task automatic keep_option_value();
    if (walk_code == OPT_LEASE) lease_kept = walk_value;
    if (walk_code == OPT_RENEWAL) renewal_kept = walk_value;
    if (walk_code == OPT_REBINDING) rebinding_kept = walk_value;
  endtask

  task automatic fill_running(inout result_item_t r);
    r.lease_seconds = lease_kept;
    r.renewal_seconds = renewal_kept;
    r.rebinding_seconds = rebinding_kept;
    r.offer_total = 16'(offers);
    r.max_lease_seconds = lease_peak;
    r.address_seen = wanted_hit;
    r.server_hits = 16'(server_hit_sum);
  endtask

  // Advance the predicted state by one accepted item; queue the result it causes.
  task automatic judge_item(input byte_item_t it);
    result_item_t r;
    int unsigned hits;
    logic [7:0] b;
    r = '0;
    hits = 0;
    b = it.data_byte;
    if (it.mode) begin
      r.kind = KIND_REPORT;
      if (offers == 0) r.status = STATUS_CRITICAL;
      else if (setting.server_count > 0 && server_hit_sum == 0) r.status = STATUS_CRITICAL;
      else if (server_hit_sum < setting.server_count) r.status = STATUS_WARNING;
      else if (setting.address_check_enable && !wanted_hit) r.status = STATUS_WARNING;
      else r.status = STATUS_OK;
      fill_running(r);
      outcomes_due.push_back(r);
    end else begin
      if (pkt_pos < PACKET_LIMIT) begin
        if (pkt_pos >= 4 && pkt_pos < 8) begin
          if (b != setting.expected_xid[8*(7-pkt_pos) +: 8]) pkt_good = 1'b0;
        end
        if (pkt_pos >= 16 && pkt_pos < 20) yiaddr_acc = {yiaddr_acc[23:0], b};
        if (pkt_pos >= 28 && pkt_pos < 34) begin
          if (b != setting.client_mac[8*(33-pkt_pos) +: 8]) pkt_good = 1'b0;
        end
        if (pkt_pos >= OPTIONS_FROM && pkt_good && !walk_done) begin
          case (walk_phase)
            WANT_CODE: begin
              if (b == OPT_PAD || b == OPT_END) begin
                walk_done = 1'b1;
              end else begin
                walk_code = b;
                walk_phase = WANT_LENGTH;
              end
            end
            WANT_LENGTH: begin
              walk_left = b;
              walk_value = '0;
              walk_taken = 0;
              if (b == 8'd0) begin
                keep_option_value();
                walk_phase = WANT_CODE;
              end else begin
                walk_phase = WANT_DATA;
              end
            end
            default: begin
              // only the first four data bytes make up the value
              if (walk_taken < 4) begin
                walk_value = {walk_value[23:0], b};
                walk_taken++;
              end
              walk_left = walk_left - 8'd1;
              if (walk_left == 8'd0) begin
                keep_option_value();
                walk_phase = WANT_CODE;
              end
            end
          endcase
        end
        pkt_pos++;
      end
      if (it.last_byte) begin
        r.kind = KIND_VERDICT;
        r.accepted = pkt_good && pkt_pos >= MIN_CHECKED_BYTES;
        if (r.accepted) begin
          offers = (offers >= COUNT_LIMIT) ? COUNT_LIMIT : offers + 1;
          if (lease_kept > lease_peak || lease_kept == INFINITE_TIME) lease_peak = lease_kept;
          if (yiaddr_acc == setting.wanted_address) wanted_hit = 1'b1;
          if (setting.server_count > 0 && it.sender_address == setting.server_a) hits++;
          if (setting.server_count > 1 && it.sender_address == setting.server_b) hits++;
          if (setting.server_count > 2 && it.sender_address == setting.server_c) hits++;
          server_hit_sum = (server_hit_sum + hits > COUNT_LIMIT) ?
                           COUNT_LIMIT : server_hit_sum + hits;
        end
        r.offered_ip = yiaddr_acc;
        r.status = STATUS_OK;
        fill_running(r);
        outcomes_due.push_back(r);
        pkt_pos = 0;
        pkt_good = 1'b1;
        walk_phase = WANT_CODE;
        walk_code = '0;
        walk_left = '0;
        walk_value = '0;
        walk_taken = 0;
        walk_done = 1'b0;
        yiaddr_acc = '0;
      end
    end
  endtask

  // Entered and left on a falling edge; valid stays up on exit so that a
  // following item can go out back to back.
  task automatic send_item(input byte_item_t it);
    int unsigned pause;
    pause = draw_pause(quiet_sender);
    if (pause > 0) begin
      byte_valid <= 1'b0;
      repeat (pause) @(negedge clk);
    end
    byte_item <= it;
    byte_valid <= 1'b1;
    @(posedge clk);
    while (byte_ready !== 1'b1) @(posedge clk);
    judge_item(it);
    @(negedge clk);
  endtask

  task automatic send_report();
    byte_item_t it;
    it.mode = 1'b1;
    it.data_byte = 8'($urandom_range(0, 255));
    it.sender_address = $urandom;
    it.last_byte = 1'($urandom_range(0, 1));
    send_item(it);
  endtask

  // report_odds: one chance in that many of a report before each byte, 0 for none
  task automatic send_packet(input logic [31:0] from, input int unsigned report_odds);
    byte_item_t it;
    foreach (packet_bytes[i]) begin
      if (report_odds != 0 && $urandom_range(1, report_odds) == 1) send_report();
      it.mode = 1'b0;
      it.data_byte = packet_bytes[i];
      it.last_byte = (i == packet_bytes.size() - 1);
      it.sender_address = it.last_byte ? from : $urandom;
      send_item(it);
    end
  endtask

  task automatic await_all_outcomes();
    byte_valid <= 1'b0;
    @(negedge clk);
    while (outcomes_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [47:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
  endtask

  task automatic apply_settings(input cfg_t c);
    await_all_outcomes();
    write_reg(REG_EXPECTED_XID, 48'(c.expected_xid));
    write_reg(REG_CLIENT_MAC, c.client_mac);
    write_reg(REG_WANTED_ADDRESS, 48'(c.wanted_address));
    write_reg(REG_ADDR_CHECK_EN, 48'(c.address_check_enable));
    write_reg(REG_SERVER_COUNT, 48'(c.server_count));
    write_reg(REG_SERVER_A, 48'(c.server_a));
    write_reg(REG_SERVER_B, 48'(c.server_b));
    write_reg(REG_SERVER_C, 48'(c.server_c));
    cfg_write <= 1'b0;
    @(negedge clk);
    setting = c;
  endtask

  // fixed header with the current transaction id and hardware address, through the cookie
  task automatic build_header(input logic [31:0] yiaddr);
    logic [7:0] b;
    packet_bytes.delete();
    for (int i = 0; i < OPTIONS_FROM; i++) begin
      if (i >= 4 && i < 8) b = setting.expected_xid[8*(7-i) +: 8];
      else if (i >= 16 && i < 20) b = yiaddr[8*(19-i) +: 8];
      else if (i >= 28 && i < 34) b = setting.client_mac[8*(33-i) +: 8];
      else if (i >= FIXED_HEADER_BYTES) b = MAGIC_COOKIE[8*(OPTIONS_FROM-1-i) +: 8];
      else b = 8'($urandom_range(0, 255));
      packet_bytes.push_back(b);
    end
  endtask

  task automatic cut_packet(input int unsigned len);
    while (packet_bytes.size() > len) void'(packet_bytes.pop_back());
  endtask

  // value goes big-endian into the first min(len,4) data bytes, the rest is noise
  task automatic add_option(input logic [7:0] code, input int unsigned len,
                            input logic [31:0] value);
    int unsigned lead;
    lead = (len < 4) ? len : 4;
    packet_bytes.push_back(code);
    packet_bytes.push_back(8'(len));
    for (int unsigned k = 0; k < len; k++) begin
      if (k < lead) packet_bytes.push_back(value[8*(lead-1-k) +: 8]);
      else packet_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic build_random_offer();
    logic [31:0] yi;
    logic [31:0] value;
    logic [7:0] code;
    int unsigned len;
    int unsigned shape;
    int unsigned target;
    yi = $urandom_range(0, 1) ? setting.wanted_address : $urandom;
    build_header(yi);
    if ($urandom_range(0, 9) == 0)
      packet_bytes[4 + $urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
    if ($urandom_range(0, 9) == 0)
      packet_bytes[28 + $urandom_range(0, 5)] ^= 8'(1 << $urandom_range(0, 7));
    shape = $urandom_range(0, 9);
    if (shape < 2) begin
      cut_packet($urandom_range(1, 60));
    end else begin
      repeat ($urandom_range(0, 5)) begin
        case ($urandom_range(0, 5))
          0, 3: code = OPT_LEASE;
          1: code = OPT_RENEWAL;
          2: code = OPT_REBINDING;
          default: code = 8'($urandom_range(1, 254));
        endcase
        case ($urandom_range(0, 19))
          0, 1: len = 0;
          2, 3, 4: len = $urandom_range(1, 8);
          5: len = $urandom_range(9, 255);
          default: len = 4;
        endcase
        case ($urandom_range(0, 4))
          0: value = INFINITE_TIME;
          1: value = $urandom_range(0, 100000);
          default: value = $urandom;
        endcase
        add_option(code, len, value);
      end
      // no terminator at all leaves the walk open to the packet end
      case ($urandom_range(0, 3))
        0: packet_bytes.push_back(OPT_PAD);
        1: ;
        default: packet_bytes.push_back(OPT_END);
      endcase
      repeat ($urandom_range(0, 12)) packet_bytes.push_back(8'($urandom_range(0, 255)));
      if (shape == 9) begin
        target = $urandom_range(540, 600);
        while (packet_bytes.size() < target)
          packet_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic check_field(input string label, input logic [47:0] want,
                             input logic [47:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, label, want, got);
    end
  endtask

  // result side: random stalls, then compare against the oldest expectation
  initial begin : result_checker
    result_item_t want;
    int unsigned stall;
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) quiet_receiver = !quiet_receiver;
      stall = draw_pause(quiet_receiver);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (result_valid !== 1'b1) @(posedge clk);
      if (outcomes_due.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing due, expected none, got %h", $time, result_item);
      end else begin
        want = outcomes_due.pop_front();
        check_field("kind", 48'(want.kind), 48'(result_item.kind));
        check_field("accepted", 48'(want.accepted), 48'(result_item.accepted));
        check_field("offered_ip", 48'(want.offered_ip), 48'(result_item.offered_ip));
        check_field("lease_seconds", 48'(want.lease_seconds), 48'(result_item.lease_seconds));
        check_field("renewal_seconds", 48'(want.renewal_seconds),
                    48'(result_item.renewal_seconds));
        check_field("rebinding_seconds", 48'(want.rebinding_seconds),
                    48'(result_item.rebinding_seconds));
        check_field("status", 48'(want.status), 48'(result_item.status));
        check_field("offer_total", 48'(want.offer_total), 48'(result_item.offer_total));
        check_field("max_lease_seconds", 48'(want.max_lease_seconds),
                    48'(result_item.max_lease_seconds));
        check_field("address_seen", 48'(want.address_seen), 48'(result_item.address_seen));
        check_field("server_hits", 48'(want.server_hits), 48'(result_item.server_hits));
      end
      @(negedge clk);
    end
  end

  task automatic test_idle_report();
    send_report();
  endtask

  task automatic test_header_checks();
    apply_settings(make_settings('0, '0, 32'hC0A8_0164, 1'b0, 2'd0, '0, '0, '0));
    // one byte, part of the yiaddr, one short of the mac, exactly through the mac
    build_header(32'h0A00_0005);
    cut_packet(1);
    send_packet(32'h0, 0);
    build_header(32'h0A00_0005);
    cut_packet(18);
    send_packet(32'h0, 0);
    build_header(32'h0A00_0005);
    cut_packet(MIN_CHECKED_BYTES - 1);
    send_packet(32'h0, 0);
    build_header(32'h0A00_0005);
    cut_packet(MIN_CHECKED_BYTES);
    send_packet(32'h0, 0);
    apply_settings(make_settings('1, '1, '1, 1'b0, 2'd0, '1, '1, '1));
    build_header(32'h0A00_0006);
    send_packet(32'hFFFF_FFFF, 0);
    build_header(32'h0A00_0006);
    packet_bytes[7] ^= 8'h10;
    send_packet(32'hFFFF_FFFF, 0);
    build_header(32'h0A00_0006);
    packet_bytes[28] ^= 8'h01;
    send_packet(32'hFFFF_FFFF, 0);
    send_report();
  endtask

  task automatic test_option_values();
    apply_settings(make_settings(32'h1234_5678, 48'h0002_B3C4_D5E6, 32'hC0A8_0164, 1'b0,
                                 2'd0, '0, '0, '0));
    // end marker stops the walk: the trailing lease must not be taken
    build_header(32'h0A00_0007);
    add_option(OPT_LEASE, 4, 32'h0001_5180);
    add_option(OPT_RENEWAL, 4, 32'h0000_A8C0);
    add_option(OPT_REBINDING, 4, 32'h0001_2750);
    packet_bytes.push_back(OPT_END);
    add_option(OPT_LEASE, 4, 32'hDEAD_BEEF);
    send_packet(32'h0A00_0001, 0);
    // zero, short and over-long lengths, an unknown option, then pad ends the walk
    build_header(32'h0A00_0007);
    add_option(OPT_LEASE, 0, 32'h0);
    add_option(OPT_RENEWAL, 2, 32'h0000_BEEF);
    add_option(OPT_REBINDING, 6, 32'h1122_3344);
    add_option(8'd12, 3, 32'h0061_6263);
    packet_bytes.push_back(OPT_PAD);
    add_option(OPT_LEASE, 4, 32'h5555_5555);
    send_packet(32'h0A00_0001, 0);
    build_header(32'h0A00_0007);
    add_option(OPT_LEASE, 4, INFINITE_TIME);
    packet_bytes.push_back(OPT_END);
    send_packet(32'h0A00_0001, 0);
    build_header(32'h0A00_0007);
    add_option(OPT_LEASE, 4, 32'h0000_0010);
    packet_bytes.push_back(OPT_END);
    send_packet(32'h0A00_0001, 40);
    // rejected packet leaves the kept times alone
    build_header(32'h0A00_0007);
    packet_bytes[4] ^= 8'h80;
    add_option(OPT_LEASE, 4, 32'h0000_0077);
    send_packet(32'h0A00_0001, 0);
    // packet ends inside an option's data, then on an option's code byte
    build_header(32'h0A00_0007);
    packet_bytes.push_back(OPT_LEASE);
    packet_bytes.push_back(8'd4);
    packet_bytes.push_back(8'hAA);
    packet_bytes.push_back(8'hBB);
    send_packet(32'h0A00_0001, 0);
    build_header(32'h0A00_0007);
    packet_bytes.push_back(OPT_RENEWAL);
    send_packet(32'h0A00_0001, 0);
    send_report();
  endtask

  task automatic test_option_area_edges();
    // renewal option runs past the option area; later bytes are beyond it too
    build_header(32'h0A00_0009);
    add_option(8'd1, 255, $urandom);
    add_option(OPT_RENEWAL, 60, 32'h0BAD_0BAD);
    add_option(OPT_LEASE, 4, 32'h0000_0001);
    send_packet(32'h0A00_0002, 0);
    // lease data finishes on the very last byte of the option area
    build_header(32'h0A00_0009);
    add_option(8'd1, 255, $urandom);
    add_option(8'd1, 45, $urandom);
    add_option(OPT_LEASE, 2, 32'h0000_4321);
    add_option(OPT_REBINDING, 4, 32'h0BAD_F00D);
    while (packet_bytes.size() < 560) packet_bytes.push_back(8'($urandom_range(0, 255)));
    send_packet(32'h0A00_0002, 0);
    send_report();
  endtask

  task automatic test_report_status();
    apply_settings(make_settings(32'hCAFE_F00D, 48'h0A0B_0C0D_0E0F, 32'hC0A8_0164, 1'b1,
                                 2'd2, 32'h0A00_0001, 32'hFFFF_FFFF, 32'h0));
    send_report();
    build_header(32'h0A00_0008);
    send_packet(32'h0A00_0001, 0);
    send_report();
    build_header(32'h0A00_0008);
    send_packet(32'hFFFF_FFFF, 0);
    send_report();
    build_header(32'hC0A8_0164);
    send_packet(32'h0A00_00FE, 0);
    send_report();
    apply_settings(make_settings(32'hCAFE_F00D, 48'h0A0B_0C0D_0E0F, 32'hC0A8_0164, 1'b1,
                                 2'd3, '0, '0, '0));
    send_report();
    build_header(32'h0A00_0008);
    send_packet(32'h0, 0);
    send_report();
    apply_settings(make_settings(32'hCAFE_F00D, 48'h0A0B_0C0D_0E0F, '0, 1'b0,
                                 2'd0, '0, '0, '0));
    send_report();
  endtask

  task automatic test_random_offers();
    cfg_t c;
    logic [31:0] from;
    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 0) c = make_settings('1, '1, '1, 1'b1, 2'd3, '1, '1, '1);
      else if (phase == 1) c = make_settings('0, '0, '0, 1'b0, 2'd0, '0, '0, '0);
      else c = make_settings($urandom, 48'({$urandom, $urandom}), $urandom,
                             1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                             $urandom, $urandom, $urandom);
      apply_settings(c);
      for (int n = 0; n < 12; n++) begin
        quiet_sender = ($urandom_range(0, 3) == 0);
        build_random_offer();
        case ($urandom_range(0, 4))
          0: from = setting.server_a;
          1: from = setting.server_b;
          2: from = setting.server_c;
          default: from = $urandom;
        endcase
        send_packet(from, ($urandom_range(0, 4) == 0) ? 150 : 0);
        if ($urandom_range(0, 3) == 0) send_report();
      end
      quiet_sender = 1'b0;
      send_report();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_idle_report();
    test_header_checks();
    test_option_values();
    test_option_area_edges();
    test_report_status();
    test_random_offers();
    await_all_outcomes();
    if (mismatches == 0 && outcomes_due.size() == 0) begin
      $display("dhcp_offer_filter_and_checker test passed");
    end else begin
      $display("dhcp_offer_filter_and_checker test failed");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("dhcp_offer_filter_and_checker test failed");
    $finish;
  end

endmodule

// ===== dhcp_offer_filter_and_checker.f =====
+incdir+design
design/dofc_pkg.sv
design/dofc_front.sv
design/dofc_queue.sv
design/dofc_back.sv
design/dhcp_offer_filter_and_checker.sv
dv/dhcp_offer_filter_and_checker_test.sv
